>>> rtl/core/pk17s_pkg.sv
// Shared constants, codes and types of the packed 17-bit three-dimensional store.
package pk17s_pkg;

    localparam int ELEM_BITS        = 17;
    localparam int GROUP_ELEMS      = 8;
    localparam int WINDOW_BITS      = 24;
    localparam int BYTE_BITS        = 8;
    localparam int IDX_BITS         = 12;
    localparam int DIM_BITS         = 13;
    localparam int MUL_A_W          = 26;
    localparam int LIN_W            = MUL_A_W + DIM_BITS;
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    // Register indexes, taken from the word address bit of the APB port.
    localparam logic CFG_DIM_WIDTH  = 1'b0;
    localparam logic CFG_DIM_HEIGHT = 1'b1;

    // Operation codes of a request.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [DIM_BITS-1:0]    DIM_RESET = DIM_BITS'(1);
    localparam logic [WINDOW_BITS-1:0] ELEM_MASK = WINDOW_BITS'((1 << ELEM_BITS) - 1);

    typedef struct packed {
        logic [DIM_BITS-1:0] dim_width;
        logic [DIM_BITS-1:0] dim_height;
    } cfg_t;

endpackage

>>> rtl/core/pk17s_if.sv
// Request and response channel interfaces of the packed 17-bit store.
interface pk17s_req_if import pk17s_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [IDX_BITS-1:0] idx_first;
    logic [IDX_BITS-1:0] idx_second;
    logic [IDX_BITS-1:0] idx_third;
    logic [ELEM_BITS-1:0] write_data;

    modport source (
        output valid, func, idx_first, idx_second, idx_third, write_data,
        input  ready
    );
    modport sink (
        input  valid, func, idx_first, idx_second, idx_third, write_data,
        output ready
    );
endinterface

interface pk17s_rsp_if import pk17s_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] read_data;
    logic                 out_of_range;

    modport source (
        output valid, read_data, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, read_data, out_of_range,
        output ready
    );
endinterface

>>> rtl/core/pk17s_core.sv
// Sequencer, shared multiply-add unit and packed byte memory of the 17-bit store.
module pk17s_core
    import pk17s_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    pk17s_req_if.sink          req,
    pk17s_rsp_if.source        rsp
);

    localparam int STORE_BYTES = (MAX_ELEMENTS * ELEM_BITS) / GROUP_ELEMS + 1;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int IDX_W       = $clog2(MAX_ELEMENTS);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ADDR,
        ST_READ,
        ST_RWAIT,
        ST_EXTRACT,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [1:0]             cnt_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   out_valid_reg;
    logic                   rd_vld_reg;

    logic                   func_reg;
    logic [IDX_BITS-1:0]    i1_reg;
    logic [IDX_BITS-1:0]    i2_reg;
    logic [IDX_BITS-1:0]    i3_reg;
    logic [ELEM_BITS-1:0]   wd_reg;
    logic [LIN_W-1:0]       acc_reg;
    logic [2:0]             pos_reg;
    logic [WINDOW_BITS-1:0] win_reg;
    logic [ELEM_BITS-1:0]   res_data_reg;
    logic                   res_oor_reg;
    logic [ELEM_BITS-1:0]   out_data_reg;
    logic                   out_oor_reg;

    logic [BYTE_BITS-1:0]   store_mem [STORE_BYTES];
    logic [BYTE_BITS-1:0]   rdata_reg;

    logic                   accept;
    logic                   out_free;
    logic                   in_range;
    logic [MUL_A_W-1:0]     mul_a;
    logic [DIM_BITS-1:0]    mul_b;
    logic [IDX_BITS-1:0]    mul_add;
    logic [LIN_W-1:0]       mul_p;
    logic [LIN_W-1:0]       prod;
    logic [ADDR_W-1:0]      lin_a;
    logic [ADDR_W-1:0]      grp;
    logic [ADDR_W-1:0]      base;
    logic [2:0]             shift;
    logic [WINDOW_BITS-1:0] field_mask;
    logic [WINDOW_BITS-1:0] win_merged;
    logic [ELEM_BITS-1:0]   elem;
    logic                   mem_we;
    logic [BYTE_BITS-1:0]   mem_wdata;
    logic                   mem_re;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.out_of_range = out_oor_reg;

    // The single multiply-add unit computes (idx_first*W + idx_second)*H + idx_third
    // in the states ST_MUL1 and then ST_MUL2.
    always_comb
    begin
        if (state_reg == ST_MUL1)
        begin
            mul_a   = MUL_A_W'(i1_reg);
            mul_b   = cfg.dim_width;
            mul_add = i2_reg;
        end
        else
        begin
            mul_a   = acc_reg[MUL_A_W-1:0];
            mul_b   = cfg.dim_height;
            mul_add = i3_reg;
        end
        mul_p = mul_a * mul_b;
        prod  = mul_p + LIN_W'(mul_add);
    end

    // Group g, position p starts at byte 17*g + 2*p.
    always_comb
    begin
        in_range   = acc_reg < LIN_W'(MAX_ELEMENTS);
        lin_a      = ADDR_W'(acc_reg[IDX_W-1:0]);
        grp        = lin_a >> 3;
        base       = (grp << 4) + grp + ADDR_W'({lin_a[2:0], 1'b0});
        shift      = ~pos_reg;
        field_mask = ELEM_MASK << shift;
        elem       = ELEM_BITS'(win_reg >> shift);
        win_merged = (win_reg & ~field_mask) | (WINDOW_BITS'(wd_reg) << shift);
    end

    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : win_reg[WINDOW_BITS-1 -: BYTE_BITS];
        mem_re    = (state_reg == ST_READ);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[addr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= mem_re;
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == ADDR_W'(STORE_BYTES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    state_reg <= ST_ADDR;
                end
                ST_ADDR:
                begin
                    cnt_reg  <= '0;
                    addr_reg <= base;
                    state_reg <= in_range ? ST_READ : ST_DONE;
                end
                ST_READ:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                    if (cnt_reg == 2'd2)
                    begin
                        state_reg <= ST_RWAIT;
                    end
                end
                ST_RWAIT:
                begin
                    state_reg <= ST_EXTRACT;
                end
                ST_EXTRACT:
                begin
                    cnt_reg  <= '0;
                    addr_reg <= addr_reg - ADDR_W'(3);
                    state_reg <= (func_reg == FUNC_WRITE) ? ST_WRITE : ST_DONE;
                end
                ST_WRITE:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                    if (cnt_reg == 2'd2)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, steered by the sequencer state.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            i1_reg   <= req.idx_first;
            i2_reg   <= req.idx_second;
            i3_reg   <= req.idx_third;
            wd_reg   <= req.write_data;
        end
        if (state_reg == ST_MUL1 || state_reg == ST_MUL2)
        begin
            acc_reg <= prod;
        end
        if (state_reg == ST_ADDR)
        begin
            pos_reg      <= acc_reg[2:0];
            res_data_reg <= '0;
            res_oor_reg  <= !in_range;
        end
        if (rd_vld_reg)
        begin
            win_reg <= {win_reg[WINDOW_BITS-BYTE_BITS-1:0], rdata_reg};
        end
        else if (state_reg == ST_EXTRACT)
        begin
            win_reg      <= win_merged;
            res_data_reg <= (func_reg == FUNC_WRITE) ? wd_reg : elem;
        end
        else if (state_reg == ST_WRITE)
        begin
            win_reg <= win_reg << BYTE_BITS;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= res_data_reg;
            out_oor_reg  <= res_oor_reg;
        end
    end

    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL1)
        else $error("accepted request did not start the multiply sequence");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the completion step");

    a_read_data_timing: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_READ || state_reg == ST_RWAIT))
        else $error("memory read data returned outside the read sequence");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.out_of_range) |-> rsp.read_data == '0)
        else $error("out-of-range response carries nonzero data");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (32'(addr_reg) < STORE_BYTES))
        else $error("byte write beyond the store");

endmodule

>>> rtl/core/packed_17bit_3d_array_store_top.sv
// Top level of the packed 17-bit store: configuration registers and the sequenced core.
// A request is taken only in the idle state, so a new one waits until the last has passed
// into the response register. The sequence is two passes through one multiply-add unit,
// then three byte reads (plus three byte writes) on a byte-wide memory; an out-of-range
// index skips the memory and goes straight to the response.
// Reset: registers go to 1, then a clearing pass zeroes the memory one byte a cycle
// (all MAX_ELEMENTS*17/8+1 bytes, 8705 by default) before the first request is taken.
module packed_17bit_3d_array_store_top
    import pk17s_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    pk17s_req_if.sink             req,
    pk17s_rsp_if.source           rsp
);

    cfg_t cfg_reg;
    logic reg_sel;
    logic cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_width  <= DIM_RESET;
            cfg_reg.dim_height <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                CFG_DIM_WIDTH:  cfg_reg.dim_width  <= pwdata[DIM_BITS-1:0];
                CFG_DIM_HEIGHT: cfg_reg.dim_height <= pwdata[DIM_BITS-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            CFG_DIM_WIDTH:  prdata = APB_DATA_W'(cfg_reg.dim_width);
            CFG_DIM_HEIGHT: prdata = APB_DATA_W'(cfg_reg.dim_height);
            default:        prdata = '0;
        endcase
    end

    pk17s_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> bench/tb_packed_17bit_3d_array_store_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the packed 17-bit three-dimensional store with a shadow byte store.
module tb_packed_17bit_3d_array_store_top;
    import pk17s_pkg::*;

    localparam int STORE_ELEMS  = MAX_ELEMENTS_DEF;
    localparam int STORE_BYTES  = MAX_ELEMENTS_DEF * ELEM_BITS / GROUP_ELEMS + 1;
    localparam int PHASE_ITEMS  = 173;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int QUIET_LIMIT  = 40000;
    localparam int DIRECTED_LEN = 23;
    localparam int PHASE_COUNT  = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                 func;
        logic [IDX_BITS-1:0]  idx_first;
        logic [IDX_BITS-1:0]  idx_second;
        logic [IDX_BITS-1:0]  idx_third;
        logic [ELEM_BITS-1:0] write_data;
    } request_t;

    typedef struct packed {
        logic [ELEM_BITS-1:0] read_data;
        logic                 out_of_range;
    } result_t;

    typedef struct packed {
        request_t rq;
        logic     typed;
        result_t  want;
    } dir_row_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        idle_mode_t          mode;
    } phase_t;

    // Directed requests under the reset dimensions, where the linear index is the sum of indices.
    dir_row_t dir_rows [DIRECTED_LEN] = '{
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd0,    17'h00000}, 1'b1, '{17'h00000, 1'b0}},
        '{'{FUNC_WRITE, 12'd0,    12'd0,    12'd0,    17'h1FFFF}, 1'b1, '{17'h1FFFF, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd0,    17'h00000}, 1'b1, '{17'h1FFFF, 1'b0}},
        '{'{FUNC_WRITE, 12'd0,    12'd0,    12'd1,    17'h00000}, 1'b1, '{17'h00000, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd0,    17'h00000}, 1'b0, '{17'h00000, 1'b0}},
        '{'{FUNC_WRITE, 12'd4095, 12'd0,    12'd0,    17'h1FFFF}, 1'b1, '{17'h1FFFF, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd4095, 17'h00000}, 1'b1, '{17'h1FFFF, 1'b0}},
        '{'{FUNC_WRITE, 12'd4095, 12'd0,    12'd1,    17'h0AAAA}, 1'b1, '{17'h00000, 1'b1}},
        '{'{FUNC_READ,  12'd4095, 12'd4095, 12'd4095, 17'h00000}, 1'b1, '{17'h00000, 1'b1}},
        '{'{FUNC_WRITE, 12'd0,    12'd4095, 12'd4095, 17'h00000}, 1'b1, '{17'h00000, 1'b1}},
        '{'{FUNC_READ,  12'd0,    12'd4095, 12'd1,    17'h00000}, 1'b1, '{17'h00000, 1'b1}},
        '{'{FUNC_WRITE, 12'd0,    12'd0,    12'd6,    17'h15555}, 1'b1, '{17'h15555, 1'b0}},
        '{'{FUNC_WRITE, 12'd0,    12'd0,    12'd7,    17'h0AAAA}, 1'b1, '{17'h0AAAA, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd6,    17'h00000}, 1'b0, '{17'h00000, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd7,    17'h00000}, 1'b0, '{17'h00000, 1'b0}},
        '{'{FUNC_WRITE, 12'd0,    12'd0,    12'd2,    17'h1FFFF}, 1'b1, '{17'h1FFFF, 1'b0}},
        '{'{FUNC_WRITE, 12'd0,    12'd0,    12'd3,    17'h1FFFF}, 1'b1, '{17'h1FFFF, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd1,    12'd1,    17'h00000}, 1'b0, '{17'h00000, 1'b0}},
        '{'{FUNC_WRITE, 12'd1,    12'd2,    12'd3,    17'h10001}, 1'b1, '{17'h10001, 1'b0}},
        '{'{FUNC_READ,  12'd2,    12'd2,    12'd2,    17'h00000}, 1'b0, '{17'h00000, 1'b0}},
        '{'{FUNC_READ,  12'd0,    12'd0,    12'd5,    17'h00000}, 1'b0, '{17'h00000, 1'b0}},
        '{'{FUNC_WRITE, 12'd2047, 12'd2047, 12'd1,    17'h00000}, 1'b1, '{17'h00000, 1'b0}},
        '{'{FUNC_READ,  12'd4095, 12'd0,    12'd0,    17'h00000}, 1'b0, '{17'h00000, 1'b0}}
    };

    phase_t phases [PHASE_COUNT] = '{
        '{13'd1,    13'd1,    IDLE_NONE},
        '{13'd16,   13'd16,   IDLE_SENDER},
        '{13'd4096, 13'd1,    IDLE_RECEIVER},
        '{13'd0,    13'd8191, IDLE_BOTH},
        '{13'd8191, 13'd0,    IDLE_NONE},
        '{13'd1,    13'd4096, IDLE_SENDER},
        '{13'd7,    13'd9,    IDLE_RECEIVER},
        '{13'd8191, 13'd8191, IDLE_BOTH},
        '{13'd0,    13'd0,    IDLE_NONE},
        '{13'd4096, 13'd4096, IDLE_BOTH}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pk17s_req_if req_ch ();
    pk17s_rsp_if rsp_ch ();

    packed_17bit_3d_array_store_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Shadow copy of the byte store and the dimension registers.
    logic [7:0]          shadow_bytes [STORE_BYTES];
    logic [DIM_BITS-1:0] shadow_width;
    logic [DIM_BITS-1:0] shadow_height;
    result_t             pending_results [$];

    idle_mode_t  idle_mode = IDLE_NONE;
    int unsigned hold_requests = 0;
    int unsigned hot_lin = 0;
    int          n_errors = 0;
    int          n_requests = 0;
    int          n_writes = 0;
    int          n_out_of_range = 0;
    int          n_checked = 0;
    int          n_settings = 0;
    int          quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [APB_DATA_W-1:0] got,
                                   input logic [APB_DATA_W-1:0] want);
        $display("%0t mismatch: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Applies one request to the shadow store and returns the response it must produce.
    function automatic result_t store_access(input request_t rq);
        result_t                res;
        logic [63:0]            lin;
        int unsigned            pos;
        int unsigned            base;
        int unsigned            shift;
        logic [WINDOW_BITS-1:0] window;
        logic [WINDOW_BITS-1:0] field_mask;
        lin = 64'(rq.idx_first) * 64'(shadow_width) * 64'(shadow_height)
            + 64'(rq.idx_second) * 64'(shadow_height) + 64'(rq.idx_third);
        res.read_data = '0;
        res.out_of_range = 1'b1;
        if (lin >= 64'(STORE_ELEMS))
            return res;
        pos = int'(lin[2:0]);
        base = int'(lin >> 3) * ELEM_BITS + 2 * pos;
        window = {shadow_bytes[base], shadow_bytes[base + 1], shadow_bytes[base + 2]};
        shift = (WINDOW_BITS - ELEM_BITS) - pos;
        res.out_of_range = 1'b0;
        if (rq.func == FUNC_READ)
        begin
            res.read_data = ELEM_BITS'(window >> shift);
        end
        else
        begin
            field_mask = ELEM_MASK << shift;
            window = (window & ~field_mask) | (WINDOW_BITS'(rq.write_data) << shift);
            {shadow_bytes[base], shadow_bytes[base + 1], shadow_bytes[base + 2]} = window;
            res.read_data = rq.write_data;
        end
        return res;
    endfunction

    // Most requests aim at a valid element near recent traffic, so that neighbors that share
    // bytes are read back after writes; the rest carry free indices and are mostly rejected.
    function automatic request_t make_request();
        request_t    rq;
        int unsigned lin;
        int unsigned rest;
        rq.func = ($urandom_range(1) == 1) ? FUNC_WRITE : FUNC_READ;
        rq.write_data = ELEM_BITS'($urandom);
        if ($urandom_range(99) < 10)
            rq.write_data = ($urandom_range(1) == 1) ? '1 : '0;
        rq.idx_first = IDX_BITS'($urandom);
        rq.idx_second = IDX_BITS'($urandom);
        rq.idx_third = IDX_BITS'($urandom);
        if ($urandom_range(99) < 12)
            return rq;
        if ($urandom_range(99) < 40)
        begin
            lin = $urandom_range(STORE_ELEMS - 1);
            hot_lin = lin & ~32'd7;
        end
        else
        begin
            lin = (hot_lin + $urandom_range(15)) % STORE_ELEMS;
        end
        if (shadow_height == 0)
        begin
            rq.idx_third = IDX_BITS'(lin);
        end
        else if (shadow_width == 0)
        begin
            rq.idx_third = IDX_BITS'(lin % shadow_height);
            rq.idx_second = IDX_BITS'(lin / shadow_height);
        end
        else
        begin
            rest = lin / shadow_height;
            rq.idx_third = IDX_BITS'(lin % shadow_height);
            rq.idx_second = IDX_BITS'(rest % shadow_width);
            rq.idx_first = IDX_BITS'(rest / shadow_width);
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer(input request_t rq, input logic typed, input result_t typed_want);
        result_t predicted;
        req_ch.valid      <= 1'b1;
        req_ch.func       <= rq.func;
        req_ch.idx_first  <= rq.idx_first;
        req_ch.idx_second <= rq.idx_second;
        req_ch.idx_third  <= rq.idx_third;
        req_ch.write_data <= rq.write_data;
        do @(posedge clk); while (!req_ch.ready);
        predicted = store_access(rq);
        pending_results.push_back(typed ? typed_want : predicted);
        n_requests++;
        if (rq.func == FUNC_WRITE)
            n_writes++;
        if (predicted.out_of_range)
            n_out_of_range++;
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input logic index);
        return {index, 2'b00};
    endfunction

    task automatic apb_write(input logic index, input logic [DIM_BITS-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[DIM_BITS-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(index);
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (index == CFG_DIM_WIDTH)
            shadow_width = value;
        else
            shadow_height = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic index);
        logic [DIM_BITS-1:0] want;
        want = (index == CFG_DIM_WIDTH) ? shadow_width : shadow_height;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(index);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DATA_W'(want))
            report_mismatch($sformatf("register %0d", index), prdata, APB_DATA_W'(want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Response side: random stalls per phase, plus long hold-offs on request.
    initial
    begin : response_pacing
        int unsigned holds_done;
        int          hold_left;
        int unsigned stall_pct;
        holds_done = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 88 : (idle_mode == IDLE_BOTH) ? 37 : 0;
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : response_check
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_checked++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("response with no request outstanding",
                                APB_DATA_W'(rsp_ch.read_data), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                    report_mismatch("read_data", APB_DATA_W'(rsp_ch.read_data),
                                    APB_DATA_W'(want.read_data));
                if (rsp_ch.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", APB_DATA_W'(rsp_ch.out_of_range),
                                    APB_DATA_W'(want.out_of_range));
            end
        end
    end

    // Covers the clearing pass after reset as well as the long response hold-off.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned send_pct;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_READ;
        req_ch.idx_first = '0;
        req_ch.idx_second = '0;
        req_ch.idx_third = '0;
        req_ch.write_data = '0;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_bytes[i] = 8'h00;
        shadow_width = DIM_RESET;
        shadow_height = DIM_RESET;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_check(CFG_DIM_WIDTH);
        apb_check(CFG_DIM_HEIGHT);
        n_settings = 1;
        for (int i = 0; i < DIRECTED_LEN; i++)
            offer(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            apb_write(CFG_DIM_WIDTH, phases[ph].width);
            apb_write(CFG_DIM_HEIGHT, phases[ph].height);
            apb_check(CFG_DIM_WIDTH);
            apb_check(CFG_DIM_HEIGHT);
            n_settings++;
            idle_mode = phases[ph].mode;
            send_pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 37 : 0;
            // The response side stops for a long stretch while requests keep coming.
            if (ph == 2)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    drain();
                while (send_pct != 0 && $urandom_range(99) < send_pct)
                begin
                    req_ch.valid <= 1'b0;
                    @(negedge clk);
                end
                offer(make_request(), 1'b0, '0);
            end
        end

        drain();
        idle_mode = IDLE_NONE;
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Ran %0d requests (%0d writes, %0d out of range) over %0d dimension settings;",
                 n_requests, n_writes, n_out_of_range, n_settings);
        $display("%0d responses checked, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
